FILE: sv/tmlp_pkg.sv
// shared types, constants and functions of the tiny perceptron trainer
// sigmoid table built at elaboration, weights from tenths_q; no dependencies
package tmlp_pkg;

    localparam int FRAC_BITS       = 12;
    localparam int SIG_ENTRIES     = 256;
    localparam int DEF_HIDDEN      = 4;
    localparam int Q_W             = FRAC_BITS + 1;
    localparam int W_W             = 16;
    localparam int ACC_W           = 64;
    localparam int OP_W            = 32;
    localparam int LR_W            = 13;
    localparam int LR_RESET        = 2048;
    localparam int ONE_Q           = 1 << FRAC_BITS;
    localparam int SIG_SHIFT       = FRAC_BITS + 4 - $clog2(SIG_ENTRIES);
    localparam int SIG_IW          = $clog2(SIG_ENTRIES);

    localparam int HW_TENTHS [8] = '{-7, 2, 4, -6, -1, 8, 6, -4};
    localparam int OW_TENTHS [4] = '{2, -6, 5, -1};

    typedef logic [Q_W-1:0] t_sig_tab [SIG_ENTRIES];

    typedef struct packed {
        logic                   en;
        logic                   clr;
        logic signed [OP_W-1:0] opa;
        logic signed [OP_W-1:0] opb;
    } t_mac_ctl;

    typedef enum logic [4:0] {
        ST_IDLE, ST_HB, ST_HW0, ST_HW1, ST_HACT, ST_OB, ST_OW, ST_OACT,
        ST_D2A, ST_D2B, ST_D2C,
        ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7, ST_U8, ST_U9, ST_U10, ST_U11,
        ST_OB1, ST_OB2
    } t_state;

    // round to nearest, halves toward plus infinity
    function automatic logic signed [ACC_W-1:0] rnd_shift(
        input logic signed [ACC_W-1:0] v, input int s);
        logic signed [ACC_W-1:0] half;
        half = 64'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    // clamp to the signed weight range
    function automatic logic signed [W_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > 64'sd32767) return 16'sh7fff;
        if (v < -64'sd32768) return 16'sh8000;
        return v[W_W-1:0];
    endfunction

    // unsigned quotient by restoring shift and subtract, used for constant tables
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [W_W-1:0] tenths_q(input int v);
        longint mag;
        longint q;
        mag = longint'(v < 0 ? -v : v) * longint'(ONE_Q);
        q   = longint'(udiv(64'(mag + 5), 64'd10));
        return W_W'(v < 0 ? -q : q);
    endfunction

    // sigmoid(-8 + 16k/N) via an integer exp series, Q1.FRAC_BITS
    function automatic logic [Q_W-1:0] sig_entry(input int k);
        longint          d;
        logic            neg;
        longint unsigned m, den, t, term, e, num, dv;
        longint          sum;
        d    = 16 * longint'(k) - 8 * longint'(SIG_ENTRIES);
        neg  = d < 0;
        m    = longint'(neg ? -d : d);
        den  = 16 * longint'(SIG_ENTRIES);
        t    = udiv((m << 30) + (den >> 1), den);
        term = 64'd1 << 30;
        sum  = longint'(64'd1 << 30);
        for (int i = 1; i <= 14; i++) begin
            term = udiv((term * t) >> 30, 64'(i));
            if (i % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        e = sum < 0 ? 64'd0 : longint'(sum);
        for (int i = 0; i < 4; i++) e = (e * e + (64'd1 << 29)) >> 30;
        dv  = (64'd1 << 30) + e;
        num = neg ? (e << FRAC_BITS) : (64'd1 << (30 + FRAC_BITS));
        return Q_W'(udiv(num + (dv >> 1), dv));
    endfunction

    function automatic t_sig_tab build_sig_tab();
        t_sig_tab tab;
        for (int k = 0; k < SIG_ENTRIES; k++) tab[k] = sig_entry(k);
        return tab;
    endfunction

endpackage

FILE: sv/tmlp_mac.sv
// shared multiply-accumulate unit of the trainer
// depends on tmlp_pkg for the control struct and widths
module tmlp_mac import tmlp_pkg::*; (
    input  logic                    i_clk,
    input  t_mac_ctl                i_ctl,
    output logic signed [ACC_W-1:0] o_acc
);
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;

    // product of two 32-bit operands added to the accumulator or a fresh start
    always_comb begin
        n_acc = (i_ctl.clr ? '0 : r_acc) + ACC_W'(i_ctl.opa * i_ctl.opb);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
endmodule

FILE: sv/tmlp_sigmoid.sv
// sigmoid of the accumulator: rescale, clamp to [-8, 8) and table lookup
// depends on tmlp_pkg for the table builder and rounding function
module tmlp_sigmoid import tmlp_pkg::*; (
    input  logic signed [ACC_W-1:0] i_acc,
    output logic [Q_W-1:0]          o_y
);
    localparam t_sig_tab SIG_TAB = build_sig_tab();
    localparam logic signed [ACC_W-1:0] Z_LO = -(64'sd8 <<< FRAC_BITS);
    localparam logic signed [ACC_W-1:0] Z_HI = (64'sd8 <<< FRAC_BITS) - 64'sd1;

    logic signed [ACC_W-1:0]  z;
    logic signed [ACC_W-1:0]  zc;
    logic [FRAC_BITS+3:0]     zo;
    logic [SIG_IW-1:0]        idx;

    // rescale, clamp and offset into table range, then look up
    always_comb begin
        z = rnd_shift(i_acc, FRAC_BITS);
        if (z < Z_LO) zc = Z_LO;
        else if (z > Z_HI) zc = Z_HI;
        else zc = z;
        zo  = (FRAC_BITS + 4)'(zc - Z_LO);
        idx = SIG_IW'(zo >> SIG_SHIFT);
        o_y = SIG_TAB[idx];
    end
endmodule

FILE: sv/tiny_mlp_sgd_trainer.sv
// Two-input, four-hidden, one-output sigmoid perceptron with online training.
// Input channel s_axis: one transaction carries feature_a, feature_b and the
// target in tdata and the action flag in tuser (0 predict, 1 predict and train).
// Output channel m_axis: one transaction per input with the prediction made
// from the weights held before that input.
// The block is ready again for input as a predict item's result is loaded
// into the result register; a train item adds the weight update before the
// block takes the next item. The pace is set by the single shared
// multiply-accumulate unit, which performs every product in turn.
// s_axis_tready is high only while the sequencer sits idle.
// A result waits in an output register; when the receiver stalls, the block
// holds in its last forward step until the register is free, then continues.
// The learning rate is to be written through i_cfg_wen / i_cfg_wdata only
// while idle; the user is bound by this, the block itself does not enforce it.
// Reset (i_rst_n low, synchronous) restores the initial weights, zero biases,
// a learning rate of one half and drops any pending result.
// depends on tmlp_pkg, tmlp_mac and tmlp_sigmoid
module tiny_mlp_sgd_trainer import tmlp_pkg::*; #(
    parameter int HIDDEN_UNITS = DEF_HIDDEN
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wen,
    input  logic [LR_W-1:0] i_cfg_wdata,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // feature_a [15:0], feature_b [31:16], target [44:32], zero pad [47:45]
    input  logic [47:0]     s_axis_tdata,
    // action [0]
    input  logic            s_axis_tuser,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // prediction [12:0], zero pad [15:13]
    output logic [15:0]     m_axis_tdata
);
    localparam int IW = HIDDEN_UNITS > 1 ? $clog2(HIDDEN_UNITS) : 1;
    localparam logic [IW-1:0] LAST = IW'(HIDDEN_UNITS - 1);
    localparam logic signed [OP_W-1:0] ONE_OP = OP_W'(ONE_Q);

    t_state                  r_state, n_state;
    logic [IW-1:0]           r_idx, n_idx;
    logic signed [W_W-1:0]   r_x0, n_x0, r_x1, n_x1;
    logic [Q_W-1:0]          r_tgt, n_tgt, r_y, n_y;
    logic                    r_act, n_act;
    logic [LR_W-1:0]         r_lr;
    logic signed [OP_W-1:0]  r_d2, n_d2, r_d1, n_d1, r_t, n_t;
    logic [Q_W-1:0]          r_a   [HIDDEN_UNITS];
    logic [Q_W-1:0]          n_a   [HIDDEN_UNITS];
    logic signed [W_W-1:0]   r_hw0 [HIDDEN_UNITS];
    logic signed [W_W-1:0]   n_hw0 [HIDDEN_UNITS];
    logic signed [W_W-1:0]   r_hw1 [HIDDEN_UNITS];
    logic signed [W_W-1:0]   n_hw1 [HIDDEN_UNITS];
    logic signed [W_W-1:0]   r_hb  [HIDDEN_UNITS];
    logic signed [W_W-1:0]   n_hb  [HIDDEN_UNITS];
    logic signed [W_W-1:0]   r_ow  [HIDDEN_UNITS];
    logic signed [W_W-1:0]   n_ow  [HIDDEN_UNITS];
    logic signed [W_W-1:0]   r_ob, n_ob;
    logic                    r_out_valid, n_out_valid;
    logic [Q_W-1:0]          r_out_data, n_out_data;

    t_mac_ctl                mac_ctl;
    logic signed [ACC_W-1:0] acc;
    logic signed [OP_W-1:0]  acc32;
    logic [Q_W-1:0]          sig_y;
    logic signed [OP_W-1:0]  a_op, oma_op;

    tmlp_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .o_acc (acc)
    );

    tmlp_sigmoid u_sig (
        .i_acc (acc),
        .o_y   (sig_y)
    );

    assign acc32  = acc[OP_W-1:0];
    assign a_op   = OP_W'(r_a[r_idx]);
    assign oma_op = ONE_OP - a_op;

    // sequencer: next state, operand selection and state updates
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_x0        = r_x0;
        n_x1        = r_x1;
        n_tgt       = r_tgt;
        n_act       = r_act;
        n_y         = r_y;
        n_d2        = r_d2;
        n_d1        = r_d1;
        n_t         = r_t;
        n_a         = r_a;
        n_hw0       = r_hw0;
        n_hw1       = r_hw1;
        n_hb        = r_hb;
        n_ow        = r_ow;
        n_ob        = r_ob;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        mac_ctl     = '{en: 1'b0, clr: 1'b1, opa: '0, opb: '0};
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_x0    = s_axis_tdata[15:0];
                    n_x1    = s_axis_tdata[31:16];
                    n_tgt   = s_axis_tdata[44:32];
                    n_act   = s_axis_tuser;
                    n_idx   = '0;
                    n_state = ST_HB;
                end
            end
            ST_HB: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: OP_W'(r_hb[r_idx]), opb: ONE_OP};
                n_state = ST_HW0;
            end
            ST_HW0: begin
                mac_ctl = '{en: 1'b1, clr: 1'b0, opa: OP_W'(r_hw0[r_idx]), opb: OP_W'(r_x0)};
                n_state = ST_HW1;
            end
            ST_HW1: begin
                mac_ctl = '{en: 1'b1, clr: 1'b0, opa: OP_W'(r_hw1[r_idx]), opb: OP_W'(r_x1)};
                n_state = ST_HACT;
            end
            ST_HACT: begin
                n_a[r_idx] = sig_y;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = ST_OB;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_HB;
                end
            end
            ST_OB: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: OP_W'(r_ob), opb: ONE_OP};
                n_state = ST_OW;
            end
            ST_OW: begin
                mac_ctl = '{en: 1'b1, clr: 1'b0, opa: OP_W'(r_ow[r_idx]), opb: a_op};
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = ST_OACT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                end
            end
            ST_OACT: begin
                // wait here until the result register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = sig_y;
                    n_y         = sig_y;
                    n_state     = r_act ? ST_D2A : ST_IDLE;
                end
            end
            ST_D2A: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1,
                            opa: OP_W'(r_y) - OP_W'(r_tgt), opb: OP_W'(r_y)};
                n_state = ST_D2B;
            end
            ST_D2B: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: acc32, opb: ONE_OP - OP_W'(r_y)};
                n_state = ST_D2C;
            end
            ST_D2C: begin
                n_d2    = OP_W'(rnd_shift(acc, 2 * FRAC_BITS));
                n_idx   = '0;
                n_state = ST_U1;
            end
            ST_U1: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: a_op, opb: oma_op};
                n_state = ST_U2;
            end
            ST_U2: begin
                // old output weight feeds the hidden gradient
                n_t     = acc32;
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: OP_W'(r_ow[r_idx]), opb: r_d2};
                n_state = ST_U3;
            end
            ST_U3: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: acc32, opb: r_t};
                n_state = ST_U4;
            end
            ST_U4: begin
                n_d1    = OP_W'(rnd_shift(acc, 3 * FRAC_BITS));
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: a_op, opb: r_d2};
                n_state = ST_U5;
            end
            ST_U5: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: acc32, opb: OP_W'(r_lr)};
                n_state = ST_U6;
            end
            ST_U6: begin
                n_ow[r_idx] = sat16(ACC_W'(r_ow[r_idx]) - rnd_shift(acc, 2 * FRAC_BITS));
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: OP_W'(r_x0), opb: r_d1};
                n_state = ST_U7;
            end
            ST_U7: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: acc32, opb: OP_W'(r_lr)};
                n_state = ST_U8;
            end
            ST_U8: begin
                n_hw0[r_idx] = sat16(ACC_W'(r_hw0[r_idx]) - rnd_shift(acc, 2 * FRAC_BITS));
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: OP_W'(r_x1), opb: r_d1};
                n_state = ST_U9;
            end
            ST_U9: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: acc32, opb: OP_W'(r_lr)};
                n_state = ST_U10;
            end
            ST_U10: begin
                n_hw1[r_idx] = sat16(ACC_W'(r_hw1[r_idx]) - rnd_shift(acc, 2 * FRAC_BITS));
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: r_d1, opb: OP_W'(r_lr)};
                n_state = ST_U11;
            end
            ST_U11: begin
                n_hb[r_idx] = sat16(ACC_W'(r_hb[r_idx]) - rnd_shift(acc, FRAC_BITS));
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = ST_OB1;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_U1;
                end
            end
            ST_OB1: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, opa: r_d2, opb: OP_W'(r_lr)};
                n_state = ST_OB2;
            end
            ST_OB2: begin
                n_ob    = sat16(ACC_W'(r_ob) - rnd_shift(acc, FRAC_BITS));
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register and network parameters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_lr        <= LR_W'(LR_RESET);
            r_ob        <= '0;
            for (int k = 0; k < HIDDEN_UNITS; k++) begin
                r_hw0[k] <= tenths_q(HW_TENTHS[(k % 4) * 2]);
                r_hw1[k] <= tenths_q(HW_TENTHS[(k % 4) * 2 + 1]);
                r_hb[k]  <= '0;
                r_ow[k]  <= tenths_q(OW_TENTHS[k % 4]);
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_ob        <= n_ob;
            r_hw0       <= n_hw0;
            r_hw1       <= n_hw1;
            r_hb        <= n_hb;
            r_ow        <= n_ow;
            if (i_cfg_wen) begin
                r_lr <= i_cfg_wdata;
            end
        end
    end

    // working values of the current item
    always_ff @(posedge i_clk) begin
        r_x0       <= n_x0;
        r_x1       <= n_x1;
        r_tgt      <= n_tgt;
        r_act      <= n_act;
        r_y        <= n_y;
        r_d2       <= n_d2;
        r_d1       <= n_d1;
        r_t        <= n_t;
        r_a        <= n_a;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_data};
endmodule

FILE: sv/tmlp_checker.sv
// port-level checks for the trainer, attached by bind
// depends on tmlp_pkg for the configuration width
module tmlp_assertions import tmlp_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_cfg_wen,
    input logic [LR_W-1:0] i_cfg_wdata,
    input logic            s_axis_tvalid,
    input logic            s_axis_tready,
    input logic [47:0]     s_axis_tdata,
    input logic            s_axis_tuser,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input logic [15:0]     m_axis_tdata
);
    // reset drops any pending result
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // the sequencer is busy right after taking a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken while busy");

    // prediction stays within one and pad bits are zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[12:0] <= 13'd4096) && (m_axis_tdata[15:13] == 3'b000))
        else $error("prediction out of range");
endmodule

bind tiny_mlp_sgd_trainer tmlp_assertions u_tmlp_assertions (.*);

FILE: tb/tmlp_checker.sv
// predictor and scoreboard for the tiny perceptron trainer
// watches the config port and both stream channels; depends on tmlp_pkg
`timescale 1ns / 1ps

module tmlp_checker import tmlp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wen,
    input  logic [LR_W-1:0] i_cfg_wdata,
    input  logic            i_s_tvalid,
    input  logic            i_s_tready,
    input  logic [47:0]     i_s_tdata,
    input  logic            i_s_tuser,
    input  logic            i_m_tvalid,
    input  logic            i_m_tready,
    input  logic [15:0]     i_m_tdata,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_results
);

    localparam int NH = 4;
    localparam int NTAB = 256;
    localparam longint UNIT = 4096;

    localparam int HID_INIT [8] = '{-7, 2, 4, -6, -1, 8, 6, -4};
    localparam int OUT_INIT [4] = '{2, -6, 5, -1};

    logic [12:0]        sig_lut [NTAB];
    logic signed [15:0] hid_w [2*NH];
    logic signed [15:0] hid_b [NH];
    logic signed [15:0] out_w [NH];
    logic signed [15:0] out_b;
    logic [12:0]        rate;
    logic [12:0]        pred_q [$];

    // round to nearest, halves upward
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint tenths(input int v);
        longint q;
        q = ((v < 0 ? -v : v) * UNIT + 5) / 10;
        return v < 0 ? -q : q;
    endfunction

    // table entry: logistic of -8 + 16k/NTAB via series for exp(-|z|/16), squared 4 times
    function automatic logic [12:0] sig_point(input int k);
        longint d, acc;
        longint unsigned mag, t, term, e, dv, num;
        logic neg;
        d    = 16 * longint'(k) - 8 * NTAB;
        neg  = d < 0;
        mag  = neg ? -d : d;
        t    = ((mag << 30) + 8 * NTAB) / (16 * NTAB);
        term = 64'd1 << 30;
        acc  = 64'sd1 <<< 30;
        for (int i = 1; i <= 14; i++) begin
            term = ((term * t) >> 30) / i;
            if (i % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        e = acc < 0 ? 0 : acc;
        for (int i = 0; i < 4; i++) e = (e * e + (64'd1 << 29)) >> 30;
        dv  = (64'd1 << 30) + e;
        num = neg ? (e << 12) : (64'd1 << 42);
        return 13'((num + dv / 2) / dv);
    endfunction

    function automatic longint squash(input longint z);
        longint zc, idx;
        zc = z;
        if (zc < -8 * UNIT) zc = -8 * UNIT;
        if (zc > 8 * UNIT - 1) zc = 8 * UNIT - 1;
        idx = ((zc + 8 * UNIT) * NTAB) / (16 * UNIT);
        if (idx > NTAB - 1) idx = NTAB - 1;
        return sig_lut[idx];
    endfunction

    // forward pass with current weights, then the gradient step on a train item
    function automatic logic [12:0] forward_and_learn(input logic train,
        input logic signed [15:0] xa, input logic signed [15:0] xb, input logic [12:0] tg);
        longint x [2];
        longint act [NH];
        longint prev_w [NH];
        longint acc, y, d2, d1, lr;
        x[0] = xa;
        x[1] = xb;
        lr = rate;
        for (int i = 0; i < NH; i++) begin
            acc = longint'(hid_b[i]) * UNIT + longint'(hid_w[2*i]) * x[0]
                + longint'(hid_w[2*i+1]) * x[1];
            act[i] = squash(round_shift(acc, 12));
        end
        acc = longint'(out_b) * UNIT;
        for (int i = 0; i < NH; i++) acc += longint'(out_w[i]) * act[i];
        y = squash(round_shift(acc, 12));
        if (train) begin
            d2 = round_shift((y - longint'(tg)) * y * (UNIT - y), 24);
            for (int i = 0; i < NH; i++) begin
                prev_w[i] = out_w[i];
                out_w[i] = 16'(clip16(prev_w[i] - round_shift(act[i] * d2 * lr, 24)));
            end
            out_b = 16'(clip16(longint'(out_b) - round_shift(d2 * lr, 12)));
            for (int i = 0; i < NH; i++) begin
                d1 = round_shift(prev_w[i] * d2 * act[i] * (UNIT - act[i]), 36);
                for (int j = 0; j < 2; j++)
                    hid_w[2*i+j] = 16'(clip16(longint'(hid_w[2*i+j])
                        - round_shift(x[j] * d1 * lr, 24)));
                hid_b[i] = 16'(clip16(longint'(hid_b[i]) - round_shift(d1 * lr, 12)));
            end
        end
        return 13'(y);
    endfunction

    initial begin
        for (int k = 0; k < NTAB; k++) sig_lut[k] = sig_point(k);
    end

    assign o_pending = pred_q.size();

    // compare results first, then predict for the accepted input
    always @(posedge i_clk) begin
        logic [12:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < NH; i++) begin
                hid_w[2*i]   = 16'(tenths(HID_INIT[(i % 4) * 2]));
                hid_w[2*i+1] = 16'(tenths(HID_INIT[(i % 4) * 2 + 1]));
                hid_b[i]     = 0;
                out_w[i]     = 16'(tenths(OUT_INIT[i % 4]));
            end
            out_b        = 0;
            rate         = 13'd2048;
            o_fail_count = 0;
            o_results    = 0;
            pred_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                if (pred_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected result transaction tdata=%h", i_m_tdata);
                end else begin
                    want = pred_q.pop_front();
                    if (i_m_tdata !== {3'b000, want}) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("ERROR: prediction expected %0d (%h) got %h",
                                     want, {3'b000, want}, i_m_tdata);
                    end
                end
            end
            if (i_cfg_wen) rate = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready)
                pred_q.push_back(forward_and_learn(i_s_tuser, i_s_tdata[15:0],
                                                   i_s_tdata[31:16], i_s_tdata[44:32]));
        end
    end

endmodule

FILE: tb/testbench.sv
// stimulus and verdict for the tiny perceptron trainer
// drives the block and tmlp_checker; depends on tmlp_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
    import tmlp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 120;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_wen;
    logic [LR_W-1:0] i_cfg_wdata;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [47:0]     s_axis_tdata;
    logic            s_axis_tuser;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [15:0]     m_axis_tdata;

    int fail_count, pending, results;
    int idle_pct, stall_pct;
    int hold_cycles;
    int quiet_cycles;
    int items_sent;
    int trains_sent;

    tiny_mlp_sgd_trainer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    tmlp_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        m_axis_tready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 0;
                for (int n = 0; n < hold_cycles; n++) @(posedge i_clk);
                hold_cycles = 0;
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog expired, %0d results outstanding", pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // offer one input transaction, optionally after a random gap
    task automatic send_item(input logic train, input logic [15:0] fa,
                             input logic [15:0] fb, input logic [12:0] tg);
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= train;
        s_axis_tdata  <= {3'b000, tg, fb, fa};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (train) trains_sent++;
    endtask

    // wait for every expected prediction plus the trailing weight update
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [12:0] lr);
        i_cfg_wen   <= 1;
        i_cfg_wdata <= lr;
        @(posedge i_clk);
        i_cfg_wen   <= 0;
    endtask

    function automatic logic [15:0] rand_feature();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) return 16'($signed($urandom_range(0, 16383)) - 8192);
        if (pick < 9) return 16'($urandom);
        return $urandom_range(1) ? 16'h7fff : 16'h8000;
    endfunction

    function automatic logic [12:0] rand_target();
        if ($urandom_range(9) == 0) return 13'($urandom);
        return 13'($urandom_range(0, 4096));
    endfunction

    task automatic random_burst(input int count);
        for (int n = 0; n < count; n++)
            send_item($urandom_range(99) < 60, rand_feature(), rand_feature(), rand_target());
    endtask

    logic [15:0] edge_vals [5];
    logic [12:0] phase_rate [4];

    initial begin
        i_rst_n       = 0;
        i_cfg_wen     = 0;
        i_cfg_wdata   = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        s_axis_tuser  = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        quiet_cycles  = 0;
        items_sent    = 0;
        trains_sent   = 0;
        edge_vals     = '{16'h8000, 16'h7fff, 16'h0000, 16'h1000, 16'hf000};
        phase_rate    = '{13'd0, 13'd4096, 13'd8191, 13'd2048};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes with reset learning rate, both actions
        for (int k = 0; k < 5; k++) begin
            send_item(0, edge_vals[k], edge_vals[4-k], 13'd0);
            send_item(1, edge_vals[k], edge_vals[k], (k % 2) ? 13'd4096 : 13'd0);
        end
        send_item(1, 16'h7fff, 16'h8000, 13'h1fff);
        send_item(0, 16'h0000, 16'h0000, 13'd4096);
        drain();

        // directed: large rate pushes weights toward saturation
        write_rate(13'h1fff);
        for (int k = 0; k < 8; k++)
            send_item(1, (k % 2) ? 16'h7fff : 16'h8000, 16'h7fff, (k % 3) ? 13'h1fff : 13'd0);
        send_item(0, 16'h7fff, 16'h7fff, 13'd0);
        drain();

        // random phases over idle and stall mixes and learning rates
        for (int ph = 0; ph < 4; ph++) begin
            write_rate(ph == 3 ? 13'($urandom_range(0, 4096)) : phase_rate[ph]);
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            random_burst(170);
            // back-pressure: long receiver hold while inputs keep coming
            if (ph == 1 || ph == 2) hold_cycles = 400;
            random_burst(170);
            drain();
        end

        // one more pass at the reset rate
        write_rate(13'd2048);
        random_burst(30);
        drain();

        $display("covered %0d items (%0d train) and %0d results over four pacing mixes",
                 items_sent, trains_sent, results);
        $display("learning rates included 0, 4096, 8191, 2048 and a random value");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: tiny_mlp_sgd_trainer.f
sv/tmlp_pkg.sv
sv/tmlp_mac.sv
sv/tmlp_sigmoid.sv
sv/tiny_mlp_sgd_trainer.sv
sv/tmlp_checker.sv
tb/tmlp_checker.sv
tb/testbench.sv
